/* rtl/area_weighted_vertex_normals_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef AREA_WEIGHTED_VERTEX_NORMALS_MACROS_SVH
`define AREA_WEIGHTED_VERTEX_NORMALS_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define AWVN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define AWVN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/awvn_pkg.sv */
package awvn_pkg;

    localparam int POS_W      = 16;
    localparam int IDX_W      = 10;
    localparam int NRM_W      = 16;
    localparam int CRS_W      = 2 * (POS_W + 1) + 1;
    localparam int FRAC_W     = 14;
    localparam int MAG_W      = 30;
    localparam int SQ_W       = 2 * MAG_W + 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int NUM_W      = MAG_W + FRAC_W + 1;
    localparam int QUO_W      = FRAC_W + 1;
    localparam int CNT_W      = 5;
    localparam int ROOT_STEPS = ROOT_W;

    typedef enum logic [1:0] {
        CMD_STORE    = 2'd0,
        CMD_TRIANGLE = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic [IDX_W-1:0]        slot;
        logic signed [POS_W-1:0] coord_x;
        logic signed [POS_W-1:0] coord_y;
        logic signed [POS_W-1:0] coord_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } t_in_item;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    degenerate;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic signed [CRS_W-1:0] x;
        logic signed [CRS_W-1:0] y;
        logic signed [CRS_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
        logic                    degenerate;
    } t_nrm;

endpackage

/* rtl/awvn_cross.sv */
module awvn_cross import awvn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_pos i_pa,
    input  t_pos i_pb,
    input  t_pos i_pc,
    output logic o_done,
    output t_vec o_n
);

    logic signed [POS_W:0]         r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [2*POS_W+1:0]     r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic                          r_v1, r_v2, r_v3;
    t_vec                          r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        // edges
        r_e1x <= (POS_W+1)'(i_pb.x) - (POS_W+1)'(i_pa.x);
        r_e1y <= (POS_W+1)'(i_pb.y) - (POS_W+1)'(i_pa.y);
        r_e1z <= (POS_W+1)'(i_pb.z) - (POS_W+1)'(i_pa.z);
        r_e2x <= (POS_W+1)'(i_pc.x) - (POS_W+1)'(i_pa.x);
        r_e2y <= (POS_W+1)'(i_pc.y) - (POS_W+1)'(i_pa.y);
        r_e2z <= (POS_W+1)'(i_pc.z) - (POS_W+1)'(i_pa.z);
        // products
        r_p0 <= r_e1y * r_e2z;
        r_p1 <= r_e1z * r_e2y;
        r_p2 <= r_e1z * r_e2x;
        r_p3 <= r_e1x * r_e2z;
        r_p4 <= r_e1x * r_e2y;
        r_p5 <= r_e1y * r_e2x;
        // differences, held until the next item
        if (r_v2) begin
            r_n.x <= CRS_W'(r_p0) - CRS_W'(r_p1);
            r_n.y <= CRS_W'(r_p2) - CRS_W'(r_p3);
            r_n.z <= CRS_W'(r_p4) - CRS_W'(r_p5);
        end
    end

    assign o_done = r_v3;
    assign o_n    = r_n;

endmodule

/* rtl/awvn_norm.sv */
module awvn_norm import awvn_pkg::*; #(
    parameter int ACC_W = 48
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_sum_x,
    input  logic signed [ACC_W-1:0] i_sum_y,
    input  logic signed [ACC_W-1:0] i_sum_z,
    output logic                    o_done,
    output t_nrm                    o_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_SQ, S_ROOT, S_DSET, S_DIV, S_DONE
    } t_state;

    t_state              r_state;
    logic [ACC_W-1:0]    r_mx, r_my, r_mz;
    logic [2:0]          r_neg;
    logic [1:0]          r_k;
    logic [CNT_W-1:0]    r_cnt;
    logic [2*MAG_W-1:0]  r_prod;
    logic [SQ_W-1:0]     r_sq;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W:0]     r_drem;
    logic [QUO_W-1:0]    r_num;
    logic [QUO_W-1:0]    r_quo;
    t_nrm                r_res;

    logic [ACC_W-1:0]    big;
    logic [MAG_W-1:0]    m_sel;
    logic                m_neg;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic [ROOT_W:0]     dv_sh;
    logic                dv_ge;
    logic [NUM_W-1:0]    num;
    logic [QUO_W-1:0]    quo;
    logic signed [NRM_W-1:0] q_signed;

    always_comb begin
        big = r_mx;
        if (r_my > big) begin
            big = r_my;
        end
        if (r_mz > big) begin
            big = r_mz;
        end
        unique case (r_k)
            2'd0: begin
                m_sel = r_mx[MAG_W-1:0];
                m_neg = r_neg[0];
            end
            2'd1: begin
                m_sel = r_my[MAG_W-1:0];
                m_neg = r_neg[1];
            end
            2'd2: begin
                m_sel = r_mz[MAG_W-1:0];
                m_neg = r_neg[2];
            end
            default: begin
                m_sel = '0;
                m_neg = 1'b0;
            end
        endcase
        rem_sh   = {r_rem[REM_W-3:0], r_sq[SQ_W-1:SQ_W-2]};
        trial    = {1'b0, r_root, 2'b01};
        dv_sh    = {r_drem[ROOT_W-1:0], r_num[QUO_W-1]};
        dv_ge    = dv_sh >= {1'b0, r_root};
        num      = NUM_W'({m_sel, {FRAC_W{1'b0}}}) + NUM_W'(r_root >> 1);
        quo      = {r_quo[QUO_W-2:0], dv_ge};
        q_signed = m_neg ? (NRM_W'(0) - NRM_W'(quo)) : NRM_W'(quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mx  <= i_sum_x[ACC_W-1] ? ACC_W'(0) - i_sum_x : i_sum_x;
                        r_my  <= i_sum_y[ACC_W-1] ? ACC_W'(0) - i_sum_y : i_sum_y;
                        r_mz  <= i_sum_z[ACC_W-1] ? ACC_W'(0) - i_sum_z : i_sum_z;
                        r_neg <= {i_sum_z[ACC_W-1], i_sum_y[ACC_W-1], i_sum_x[ACC_W-1]};
                        r_res.degenerate <= 1'b0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (big == '0) begin
                        r_res   <= '{x: '0, y: '0, z: '0, degenerate: 1'b1};
                        r_state <= S_DONE;
                    end else if (|big[ACC_W-1:MAG_W]) begin
                        r_mx <= r_mx >> 1;
                        r_my <= r_my >> 1;
                        r_mz <= r_mz >> 1;
                    end else if (!big[MAG_W-1]) begin
                        r_mx <= r_mx << 1;
                        r_my <= r_my << 1;
                        r_mz <= r_mz << 1;
                    end else begin
                        r_k     <= 2'd0;
                        r_sq    <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= m_sel * m_sel;
                    if (r_k != 2'd0) begin
                        r_sq <= r_sq + SQ_W'(r_prod);
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_sq <= r_sq << 2;
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                        r_k     <= 2'd0;
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    r_drem  <= (ROOT_W+1)'(num[NUM_W-1:QUO_W]);
                    r_num   <= num[QUO_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_drem <= dv_ge ? dv_sh - {1'b0, r_root} : dv_sh;
                    r_quo  <= quo;
                    r_num  <= r_num << 1;
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        unique case (r_k)
                            2'd0:    r_res.x <= q_signed;
                            2'd1:    r_res.y <= q_signed;
                            default: r_res.z <= q_signed;
                        endcase
                        if (r_k == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DSET;
                        end
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

/* rtl/area_weighted_vertex_normals.sv */
// Area-weighted vertex normals. One item is taken at a time. A vertex store with an
// in-range slot is written in the cycle that accepts it. A triangle with all corners
// in range reads its three positions, presents the corners to the cross product unit,
// waits for its result, then reads and writes back each corner's accumulator entry on
// the single accumulator port. A query runs the normalizer: a one-bit-per-cycle shift
// of up to 29 steps, a 31-step square root and three 15-step divisions; a query of a
// zero accumulator skips the root and divisions, and one of an out-of-range slot skips
// the normalizer. A query also waits while the previous result is still held in the
// output register. After reset and after a clear command the accumulator memory is
// swept to zero, one entry per cycle, and no item is taken during the sweep. A result
// waits in an output register, so the next item is taken while it is held.
module area_weighted_vertex_normals import awvn_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int ACC_WIDTH    = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

`include "area_weighted_vertex_normals_macros.svh"

    localparam int ADDR_W = $clog2(MAX_VERTICES);

    typedef struct packed {
        logic                        ovf;
        logic signed [ACC_WIDTH-1:0] x;
        logic signed [ACC_WIDTH-1:0] y;
        logic signed [ACC_WIDTH-1:0] z;
    } t_acc;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PRD_A, S_PRD_B, S_PRD_C, S_PWAIT, S_CROSS,
        S_ARD, S_AWR, S_QRD, S_QDAT, S_NORM, S_OUT
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_ca, r_cb, r_cc, r_q_addr;
    logic [1:0]          r_j;
    t_pos                r_pa, r_pb;
    logic                r_sat;
    logic                r_q_bad;
    logic                r_out_valid;
    t_out_item           r_out_item;

    t_pos                pos_mem [MAX_VERTICES];
    t_pos                r_pos_rdata;
    t_acc                acc_mem [MAX_VERTICES];
    t_acc                r_acc_rdata;

    logic                in_acc;
    logic                vi_ok, ca_ok, cb_ok, cc_ok;
    logic                pos_we;
    logic [ADDR_W-1:0]   pos_addr;
    logic                acc_we;
    logic [ADDR_W-1:0]   acc_addr;
    t_acc                acc_wdata;
    logic [ADDR_W-1:0]   cur_corner;
    t_acc                sat_entry;
    logic signed [ACC_WIDTH:0] w_sx, w_sy, w_sz;
    logic                ov_x, ov_y, ov_z;
    logic signed [ACC_WIDTH-1:0] acc_max, acc_min;

    logic                cross_start, cross_done;
    t_vec                cross_n;
    logic                norm_start, norm_done;
    t_nrm                norm_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign vi_ok = 32'(i_in_item.slot) < 32'(MAX_VERTICES);
    assign ca_ok = 32'(i_in_item.corner_a) < 32'(MAX_VERTICES);
    assign cb_ok = 32'(i_in_item.corner_b) < 32'(MAX_VERTICES);
    assign cc_ok = 32'(i_in_item.corner_c) < 32'(MAX_VERTICES);

    // position memory
    always_comb begin
        pos_we   = in_acc && (i_in_item.cmd == CMD_STORE) && vi_ok;
        pos_addr = ADDR_W'(i_in_item.slot);
        unique case (r_state)
            S_PRD_A: pos_addr = r_ca;
            S_PRD_B: pos_addr = r_cb;
            S_PRD_C: pos_addr = r_cc;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_addr] <= '{x: i_in_item.coord_x, y: i_in_item.coord_y,
                                   z: i_in_item.coord_z};
        end
        r_pos_rdata <= pos_mem[pos_addr];
    end

    // saturating accumulate
    always_comb begin
        acc_max = {1'b0, {(ACC_WIDTH-1){1'b1}}};
        acc_min = {1'b1, {(ACC_WIDTH-1){1'b0}}};
        w_sx = (ACC_WIDTH+1)'(r_acc_rdata.x) + (ACC_WIDTH+1)'(cross_n.x);
        w_sy = (ACC_WIDTH+1)'(r_acc_rdata.y) + (ACC_WIDTH+1)'(cross_n.y);
        w_sz = (ACC_WIDTH+1)'(r_acc_rdata.z) + (ACC_WIDTH+1)'(cross_n.z);
        ov_x = w_sx[ACC_WIDTH] != w_sx[ACC_WIDTH-1];
        ov_y = w_sy[ACC_WIDTH] != w_sy[ACC_WIDTH-1];
        ov_z = w_sz[ACC_WIDTH] != w_sz[ACC_WIDTH-1];
        sat_entry.x   = ov_x ? (w_sx[ACC_WIDTH] ? acc_min : acc_max) : w_sx[ACC_WIDTH-1:0];
        sat_entry.y   = ov_y ? (w_sy[ACC_WIDTH] ? acc_min : acc_max) : w_sy[ACC_WIDTH-1:0];
        sat_entry.z   = ov_z ? (w_sz[ACC_WIDTH] ? acc_min : acc_max) : w_sz[ACC_WIDTH-1:0];
        sat_entry.ovf = r_acc_rdata.ovf || ov_x || ov_y || ov_z;
    end

    // accumulator memory
    always_comb begin
        unique case (r_j)
            2'd0:    cur_corner = r_ca;
            2'd1:    cur_corner = r_cb;
            default: cur_corner = r_cc;
        endcase
        acc_we    = 1'b0;
        acc_addr  = cur_corner;
        acc_wdata = sat_entry;
        unique case (r_state)
            S_CLEAR: begin
                acc_we    = 1'b1;
                acc_addr  = r_clr_addr;
                acc_wdata = '0;
            end
            S_AWR:   acc_we   = 1'b1;
            S_QRD:   acc_addr = r_q_addr;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_addr] <= acc_wdata;
        end
        r_acc_rdata <= acc_mem[acc_addr];
    end

    assign cross_start = (r_state == S_PWAIT);
    assign norm_start  = (r_state == S_QDAT);

    awvn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cross_start),
        .i_pa    (r_pa),
        .i_pb    (r_pb),
        .i_pc    (r_pos_rdata),
        .o_done  (cross_done),
        .o_n     (cross_n)
    );

    awvn_norm #(
        .ACC_W (ACC_WIDTH)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_sum_x (r_acc_rdata.x),
        .i_sum_y (r_acc_rdata.y),
        .i_sum_z (r_acc_rdata.z),
        .o_done  (norm_done),
        .o_res   (norm_res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(MAX_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_ca     <= ADDR_W'(i_in_item.corner_a);
                        r_cb     <= ADDR_W'(i_in_item.corner_b);
                        r_cc     <= ADDR_W'(i_in_item.corner_c);
                        r_q_addr <= ADDR_W'(i_in_item.slot);
                        r_q_bad  <= !vi_ok;
                        unique case (i_in_item.cmd)
                            CMD_STORE: ;
                            CMD_TRIANGLE: begin
                                if (ca_ok && cb_ok && cc_ok) begin
                                    r_state <= S_PRD_A;
                                end
                            end
                            CMD_QUERY: begin
                                r_state <= vi_ok ? S_QRD : S_OUT;
                            end
                            CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PRD_A: r_state <= S_PRD_B;
                S_PRD_B: begin
                    r_pa    <= r_pos_rdata;
                    r_state <= S_PRD_C;
                end
                S_PRD_C: begin
                    r_pb    <= r_pos_rdata;
                    r_state <= S_PWAIT;
                end
                S_PWAIT: r_state <= S_CROSS;
                S_CROSS: begin
                    if (cross_done) begin
                        r_j     <= 2'd0;
                        r_state <= S_ARD;
                    end
                end
                S_ARD: r_state <= S_AWR;
                S_AWR: begin
                    if (r_j == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_ARD;
                    end
                end
                S_QRD: r_state <= S_QDAT;
                S_QDAT: begin
                    r_sat   <= r_acc_rdata.ovf;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (norm_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        if (r_q_bad) begin
                            r_out_item <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                            degenerate: 1'b1, saturated: 1'b0};
                        end else begin
                            r_out_item <= '{normal_x: norm_res.x, normal_y: norm_res.y,
                                            normal_z: norm_res.z,
                                            degenerate: norm_res.degenerate,
                                            saturated: r_sat};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `AWVN_ASSERT_IMP(a_norm_done_owned, norm_done, r_state == S_NORM, "normalizer done outside query")
    `AWVN_ASSERT_IMP(a_cross_done_owned, cross_done, r_state == S_CROSS, "cross done outside triangle")
    `AWVN_ASSERT_IMP(a_out_from_out_state, $rose(o_out_valid), $past(r_state == S_OUT), "result without query")
    `AWVN_ASSERT_NXT(a_query_read_data, r_state == S_QRD, r_state == S_QDAT, "query read lost")

endmodule
